// File: hw/rtl/fps_pkg.sv
// shared types and constants for the five-point stencil smoother
`default_nettype none

package fps_pkg;

  localparam int SAMPLE_W     = 16;
  localparam int ROW_W        = 16;
  localparam int COLS_CFG_W   = 11;
  localparam int OUT_COL_W    = 10;
  localparam int DEF_MAX_COLS = 1024;
  localparam int MIN_DIM      = 3;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS = 2'd1;

  localparam logic [ROW_W-1:0]      FRAME_ROWS_RST = 16'd1024;
  localparam logic [COLS_CFG_W-1:0] FRAME_COLS_RST = 11'd1024;

  // five 16-bit values summed
  localparam int SUM_W = SAMPLE_W + 3;

  // floor(x / 5) = (x * ceil(2^22 / 5)) >> 22, exact for x < 2^22
  localparam int                 RECIP_W     = 20;
  localparam int                 RECIP_SHIFT = 22;
  localparam logic [RECIP_W-1:0] RECIP_5     = 20'hCCCCD;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                start_of_frame;
  } pix_word_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0]  smoothed;
    logic [ROW_W-1:0]     out_row;
    logic [OUT_COL_W-1:0] out_col;
    logic                 last_of_frame;
  } avg_word_t;

  typedef enum logic [1:0] {
    ST_RUN  = 2'b01,
    ST_FILL = 2'b10
  } fill_state_t;

endpackage

`default_nettype wire

// File: hw/rtl/fps_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module fps_ram #(
  parameter  int WIDTH = 16,
  parameter  int DEPTH = 1024,
  localparam int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output      logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/five_point_stencil_smoother.sv
// the sample below a point is summed into stage 1; its result word is registered in the output stage
// throughput: one sample per cycle while the line store prefetch matches the column
// and stage 1 is not held by a stalled output; a prefetch refill (after reset, a frame_cols
// write, or start_of_frame off column 0) stalls the input while the two line store rams are re-read
// rst is synchronous: counters, pipeline valids, prefetch state and config registers
// return to reset values; line store contents and data registers are left as they are
`default_nettype none

module five_point_stencil_smoother
  import fps_pkg::*;
#(
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  pix_valid,
  output      logic                  pix_stall,
  input  wire pix_word_t             pix_word,
  output      logic                  avg_valid,
  input  wire logic                  avg_stall,
  output      avg_word_t             avg_word,
  input  wire logic                  cfg_valid,
  output      logic                  cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int COL_W = $clog2(MAX_COLS);
  localparam int CNT_W = COL_W + 1;
  localparam int XW    = (CNT_W > COLS_CFG_W) ? CNT_W : COLS_CFG_W;
  localparam int PROD_W = SUM_W + RECIP_W;

  // configuration
  logic [ROW_W-1:0]      frame_rows;
  logic [COLS_CFG_W-1:0] frame_cols;
  logic                  cols_wr;
  logic [ROW_W-1:0]      rows_eff;
  logic [XW-1:0]         cols_eff;
  logic [XW-1:0]         cols_ext;

  // position and prefetch state
  logic [ROW_W-1:0]    row_position;
  logic [COL_W-1:0]    col_position;
  logic [COL_W-1:0]    exp_col;
  logic                pf_valid;
  logic [COL_W-1:0]    fill_col;
  fill_state_t         state;
  logic [SAMPLE_W-1:0] mid_cur;
  logic [SAMPLE_W-1:0] left_window;

  // ram ports
  logic                upper_re;
  logic [COL_W-1:0]    upper_raddr;
  logic [SAMPLE_W-1:0] upper_rdata;
  logic                mid_re;
  logic [COL_W-1:0]    mid_raddr;
  logic [SAMPLE_W-1:0] mid_rdata;

  // per-item decode
  logic [ROW_W-1:0] r_eff;
  logic [COL_W-1:0] c_eff;
  logic [COL_W-1:0] n1;
  logic [COL_W-1:0] n2;
  logic             mismatch;
  logic             accept;
  logic             produce;
  logic             last_pt;
  logic [XW-1:0]    c_plus1;
  logic [XW-1:0]    c_plus2;
  logic [ROW_W:0]   r_plus1;

  // pipeline
  logic              s1_v;
  logic [SUM_W-1:0]  s1_sum;
  logic [ROW_W-1:0]  s1_row;
  logic [OUT_COL_W-1:0] s1_col;
  logic              s1_last;
  logic              s1_ready;
  logic              s2_ready;
  logic [PROD_W-1:0] prod;

  function automatic logic [COL_W-1:0] col_next(input logic [COL_W-1:0] c,
                                                input logic [XW-1:0] cols);
    logic [XW-1:0] c1;
    c1 = XW'(c) + XW'(1);
    return (c1 >= cols) ? '0 : c1[COL_W-1:0];
  endfunction

  // configuration port
  assign cfg_ready = 1'b1;
  assign cols_wr   = cfg_valid && (cfg_index == REG_FRAME_COLS);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_rows <= FRAME_ROWS_RST;
      frame_cols <= FRAME_COLS_RST;
    end else if (cfg_valid) begin
      if (cfg_index == REG_FRAME_ROWS) begin
        frame_rows <= cfg_data[ROW_W-1:0];
      end
      if (cfg_index == REG_FRAME_COLS) begin
        frame_cols <= cfg_data[COLS_CFG_W-1:0];
      end
    end
  end

  assign cols_ext = XW'(frame_cols);

  always_comb begin
    rows_eff = (frame_rows < ROW_W'(MIN_DIM)) ? ROW_W'(MIN_DIM) : frame_rows;
    cols_eff = cols_ext;
    if (cols_ext < XW'(MIN_DIM)) begin
      cols_eff = XW'(MIN_DIM);
    end
    if (cols_ext > XW'(MAX_COLS)) begin
      cols_eff = XW'(MAX_COLS);
    end
  end

  // item decode
  always_comb begin
    r_eff    = pix_word.start_of_frame ? '0 : row_position;
    c_eff    = pix_word.start_of_frame ? '0 : col_position;
    n1       = col_next(c_eff, cols_eff);
    n2       = col_next(n1, cols_eff);
    c_plus1  = XW'(c_eff) + XW'(1);
    c_plus2  = XW'(c_eff) + XW'(2);
    r_plus1  = {1'b0, r_eff} + (ROW_W+1)'(1);
    mismatch = !pf_valid || (c_eff != exp_col);
    produce  = (r_eff >= ROW_W'(2)) && (r_eff < rows_eff) &&
               (c_eff != '0) && (c_plus2 <= cols_eff);
    last_pt  = (r_plus1 == {1'b0, rows_eff}) && (c_plus2 == cols_eff);
  end

  // handshake: stall on a prefetch miss, during refill, or when the pipeline is full
  assign s2_ready  = !avg_valid || !avg_stall;
  assign s1_ready  = !s1_v || s2_ready;
  assign pix_stall = (state == ST_FILL) || mismatch || !s1_ready;
  assign accept    = pix_valid && !pix_stall;

  // line store reads: accept prefetches column+1 (upper), column+2 (middle); refill on a miss
  always_comb begin
    upper_re    = 1'b0;
    upper_raddr = c_eff;
    mid_re      = 1'b0;
    mid_raddr   = c_eff;
    unique case (state)
      ST_RUN: begin
        if (accept) begin
          upper_re    = 1'b1;
          upper_raddr = n1;
          mid_re      = 1'b1;
          mid_raddr   = n2;
        end else if (pix_valid && mismatch) begin
          upper_re = 1'b1;
          mid_re   = 1'b1;
        end
      end
      ST_FILL: begin
        mid_re    = 1'b1;
        mid_raddr = col_next(fill_col, cols_eff);
      end
      default: begin
        upper_re = 1'b0;
        mid_re   = 1'b0;
      end
    endcase
  end

  fps_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(MAX_COLS)
  ) u_upper_ram (
    .clk  (clk),
    .we   (accept),
    .waddr(c_eff),
    .wdata(mid_cur),
    .re   (upper_re),
    .raddr(upper_raddr),
    .rdata(upper_rdata)
  );

  fps_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(MAX_COLS)
  ) u_middle_ram (
    .clk  (clk),
    .we   (accept),
    .waddr(c_eff),
    .wdata(pix_word.sample),
    .re   (mid_re),
    .raddr(mid_raddr),
    .rdata(mid_rdata)
  );

  // counters, prefetch tag and refill sequencer
  // a new row length invalidates the prefetched column
  always_ff @(posedge clk) begin
    if (rst) begin
      row_position <= '0;
      col_position <= '0;
      exp_col      <= '0;
      pf_valid     <= 1'b0;
      fill_col     <= '0;
      state        <= ST_RUN;
    end else begin
      unique case (state)
        ST_RUN: begin
          if (accept) begin
            exp_col <= n1;
            if (c_plus1 >= cols_eff) begin
              col_position <= '0;
              row_position <= (r_plus1 >= {1'b0, rows_eff}) ? '0 : r_plus1[ROW_W-1:0];
            end else begin
              col_position <= c_plus1[COL_W-1:0];
              row_position <= r_eff;
            end
          end else if (pix_valid && mismatch) begin
            fill_col <= c_eff;
            state    <= ST_FILL;
          end
          if (cols_wr) begin
            pf_valid <= 1'b0;
          end
        end
        ST_FILL: begin
          exp_col  <= fill_col;
          pf_valid <= !cols_wr;
          state    <= ST_RUN;
        end
        default: begin
          pf_valid <= 1'b0;
          state    <= ST_RUN;
        end
      endcase
    end
  end

  // column window: centre of this item, left neighbour from the previous one
  always_ff @(posedge clk) begin
    if (state == ST_FILL) begin
      mid_cur <= mid_rdata;
    end else if (accept) begin
      mid_cur     <= mid_rdata;
      left_window <= mid_cur;
    end
  end

  // stage 1: five-point sum
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (s1_ready) begin
      s1_v <= accept && produce;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && accept) begin
      s1_sum  <= SUM_W'(upper_rdata) + SUM_W'(pix_word.sample) + SUM_W'(left_window) +
                 SUM_W'(mid_rdata) + SUM_W'(mid_cur);
      s1_row  <= r_eff - ROW_W'(1);
      s1_col  <= OUT_COL_W'(c_eff);
      s1_last <= last_pt;
    end
  end

  // stage 2: divide by five through the reciprocal, into the output register
  assign prod = PROD_W'(s1_sum) * PROD_W'(RECIP_5);

  always_ff @(posedge clk) begin
    if (rst) begin
      avg_valid <= 1'b0;
    end else if (s2_ready) begin
      avg_valid <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_v) begin
      avg_word.smoothed      <= prod[RECIP_SHIFT +: SAMPLE_W];
      avg_word.out_row       <= s1_row;
      avg_word.out_col       <= s1_col;
      avg_word.last_of_frame <= s1_last;
    end
  end

`ifndef SYNTHESIS
  // a sample is only taken against a prefetch made for its own column
  a_accept_tag: assert property (@(posedge clk) disable iff (rst)
    (pix_valid && !pix_stall) |-> (pf_valid && (c_eff == exp_col)))
    else $error("sample accepted against a stale line store prefetch");

  // the refill cycle never takes a sample
  a_fill_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FILL) |-> pix_stall)
    else $error("sample accepted during line store refill");

  // a refill always leaves a usable prefetch unless the row length was rewritten
  a_fill_done: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_FILL) && !cols_wr) |=> (pf_valid && (state == ST_RUN)))
    else $error("refill did not complete");

  // full stage one behind a blocked output must hold the input off
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    (s1_v && avg_valid && avg_stall) |-> pix_stall)
    else $error("sample accepted with the pipeline blocked");
`endif

endmodule

`default_nettype wire

// File: sim/tb_five_point_stencil_smoother.sv
// testbench for the five-point stencil smoother: directed and random frames checked against a local predictor
`timescale 1ns / 1ps

module tb_five_point_stencil_smoother
  import fps_pkg::*;
();

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_AT     = 200;
  localparam int HOLD_LEN    = 80;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  pix_valid = 1'b0;
  logic                  pix_stall;
  pix_word_t             pix_word  = '0;
  logic                  avg_valid;
  logic                  avg_stall = 1'b0;
  avg_word_t             avg_word;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_FRAME_ROWS;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  five_point_stencil_smoother u_top (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix_word  (pix_word),
    .avg_valid (avg_valid),
    .avg_stall (avg_stall),
    .avg_word  (avg_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // shadow of the block: frame size, line stores, window and position
  logic [ROW_W-1:0]      rows_cfg = FRAME_ROWS_RST;
  logic [COLS_CFG_W-1:0] cols_cfg = FRAME_COLS_RST;
  logic [SAMPLE_W-1:0]   up2_row [DEF_MAX_COLS];
  logic [SAMPLE_W-1:0]   up1_row [DEF_MAX_COLS];
  logic [SAMPLE_W-1:0]   left_px = '0;
  int                    pos_row = 0;
  int                    pos_col = 0;

  pix_word_t pix_backlog [$];
  avg_word_t avg_pending [$];

  bit   pix_fire;
  int   pix_sent = 0;
  int   avg_seen = 0;
  int   mismatch_count = 0;
  int   cycle_count = 0;
  int   hold_left = 0;
  bit   hold_done = 1'b0;
  logic steady;

  // both sides run without gaps for a while
  assign steady = (pix_sent >= 600 && pix_sent < 800);

  function automatic int eff_rows();
    return (rows_cfg < 3) ? 3 : int'(rows_cfg);
  endfunction

  function automatic int eff_cols();
    int c;
    c = int'(cols_cfg);
    if (c < 3) c = 3;
    if (c > DEF_MAX_COLS) c = DEF_MAX_COLS;
    return c;
  endfunction

  task automatic average_point(input pix_word_t w);
    int nrows, ncols, r, c, ci;
    logic [SAMPLE_W-1:0] above, centre, right_v, left_v;
    logic [SUM_W-1:0] sum;
    avg_word_t res;
    nrows = eff_rows();
    ncols = eff_cols();
    if (w.start_of_frame) begin
      pos_row = 0;
      pos_col = 0;
    end
    r = pos_row;
    c = pos_col;
    ci = c % DEF_MAX_COLS;
    above = up2_row[ci];
    centre = up1_row[ci];
    right_v = up1_row[(ci + 1) % DEF_MAX_COLS];
    left_v = left_px;
    if (r >= 2 && r < nrows && c >= 1 && c + 2 <= ncols) begin
      sum = SUM_W'(above) + SUM_W'(w.sample) + SUM_W'(left_v) + SUM_W'(right_v)
          + SUM_W'(centre);
      res.smoothed = SAMPLE_W'(sum / 5);
      res.out_row = ROW_W'(r - 1);
      res.out_col = OUT_COL_W'(c);
      res.last_of_frame = (r + 1 == nrows && c + 2 == ncols);
      avg_pending.push_back(res);
    end
    // column moves down one row
    left_px = centre;
    up2_row[ci] = centre;
    up1_row[ci] = w.sample;
    c++;
    if (c >= ncols) begin
      c = 0;
      r++;
      if (r >= nrows) r = 0;
    end
    pos_row = r & 16'hFFFF;
    pos_col = c;
  endtask

  // accept words, predict and check at the rising edge
  always @(posedge clk) begin
    pix_fire = pix_valid && !pix_stall;
    if (!rst && pix_fire) begin
      average_point(pix_word);
      pix_sent++;
    end
    if (!rst && avg_valid === 1'b1 && avg_stall === 1'b0) begin
      avg_seen++;
      if (avg_pending.size() == 0) begin
        $display("%0t: unexpected word, expected none, got %p", $time, avg_word);
        mismatch_count++;
      end else begin
        avg_word_t exp_w;
        exp_w = avg_pending.pop_front();
        if (avg_word.smoothed !== exp_w.smoothed) begin
          $display("%0t: smoothed expected %0d got %0d", $time, exp_w.smoothed,
                   avg_word.smoothed);
          mismatch_count++;
        end
        if (avg_word.out_row !== exp_w.out_row) begin
          $display("%0t: out_row expected %0d got %0d", $time, exp_w.out_row,
                   avg_word.out_row);
          mismatch_count++;
        end
        if (avg_word.out_col !== exp_w.out_col) begin
          $display("%0t: out_col expected %0d got %0d", $time, exp_w.out_col,
                   avg_word.out_col);
          mismatch_count++;
        end
        if (avg_word.last_of_frame !== exp_w.last_of_frame) begin
          $display("%0t: last_of_frame expected %0b got %0b", $time, exp_w.last_of_frame,
                   avg_word.last_of_frame);
          mismatch_count++;
        end
      end
    end
  end

  // sample driver
  always @(negedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (!pix_valid || pix_fire) begin
      if (pix_backlog.size() != 0 && (steady || $urandom_range(0, 99) >= 33)) begin
        pix_word <= pix_backlog.pop_front();
        pix_valid <= 1'b1;
      end else begin
        pix_valid <= 1'b0;
      end
    end
  end

  // result receiver, with one long hold-off so the block backs up
  always @(negedge clk) begin
    if (rst) begin
      avg_stall <= 1'b0;
    end else begin
      if (!hold_done && avg_seen >= HOLD_AT) begin
        hold_left = HOLD_LEN;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        avg_stall <= 1'b1;
        hold_left--;
      end else begin
        avg_stall <= !steady && ($urandom_range(0, 99) < 33);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    if (idx == REG_FRAME_ROWS) rows_cfg = val;
    else cols_cfg = val[COLS_CFG_W-1:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic push_pix(input logic [SAMPLE_W-1:0] s, input logic sof);
    pix_word_t w;
    w.sample = s;
    w.start_of_frame = sof;
    pix_backlog.push_back(w);
  endtask

  // wait until every word is taken and every result is back, then let the pipe drain
  task automatic settle();
    while (pix_backlog.size() != 0 || pix_valid || avg_pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // mostly whole frames with random content; a stray start_of_frame now and then
  task automatic run_phase(input logic [CFG_DATA_W-1:0] rows_val,
                           input logic [CFG_DATA_W-1:0] cols_val,
                           input int n, input bit sof_first, input bit noise);
    int fsize, k;
    bit sof;
    logic [SAMPLE_W-1:0] s;
    write_reg(REG_FRAME_ROWS, rows_val);
    write_reg(REG_FRAME_COLS, cols_val);
    @(posedge clk);
    fsize = eff_rows() * eff_cols();
    k = 0;
    for (int i = 0; i < n; i++) begin
      if (i == 0) sof = sof_first;
      else if (k >= fsize) sof = ($urandom_range(0, 9) < 7);
      else sof = noise && ($urandom_range(0, 199) == 0);
      if (sof || k >= fsize) k = 0;
      case ($urandom_range(0, 9))
        0: s = '0;
        1: s = '1;
        default: s = SAMPLE_W'($urandom_range(0, 65535));
      endcase
      push_pix(s, sof);
      k++;
    end
    settle();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: sizes below range give a 3x3 frame with one interior point
    write_reg(REG_FRAME_ROWS, 16'd1);
    write_reg(REG_FRAME_COLS, 16'd2);
    @(posedge clk);
    for (int i = 0; i < 9; i++) push_pix(16'hFFFF, i == 0);
    push_pix(16'h0000, 1'b0);
    push_pix(16'hFFFF, 1'b0);
    // start of frame in the middle of a frame
    for (int i = 0; i < 9; i++) push_pix(SAMPLE_W'((i + 1) * 7919), i == 0);
    // counters wrap into the next frame without a start flag
    for (int i = 0; i < 4; i++) push_pix(16'h0001, 1'b0);
    settle();

    run_phase(16'd0, 16'd0, 150, 1'b1, 1'b1);
    // upper bits of the column write are dropped
    run_phase(16'd5, 16'hF807, 250, 1'b1, 1'b1);
    // size shrinks while a frame is open
    run_phase(16'd4, 16'd5, 120, 1'b0, 1'b1);
    // more rows while a frame is open
    run_phase(16'd9, 16'd5, 200, 1'b0, 1'b1);
    run_phase(16'hFFFF, 16'd4, 150, 1'b1, 1'b1);
    run_phase(16'd6, 16'd3, 280, 1'b1, 1'b1);

    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && avg_pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/fps_pkg.sv
hw/rtl/fps_ram.sv
hw/rtl/five_point_stencil_smoother.sv
sim/tb_five_point_stencil_smoother.sv
